@@ src/tdl_pkg.sv @@
// Shared types and constants for the table-driven lexer DFA core.
// Used by tdl_ctrl, tdl_datapath and table_driven_lexer_dfa_core.
`default_nettype none
package tdl_pkg;

    localparam int NUM_STATES    = 16;
    localparam int ALPHABET_SIZE = 256;
    localparam int MAX_RESCAN    = 8;
    localparam int POS_BITS      = 16;

    localparam int STATE_BITS = $clog2(NUM_STATES);
    localparam int CHAR_BITS  = $clog2(ALPHABET_SIZE);
    localparam int ADDR_BITS  = STATE_BITS + CHAR_BITS;
    localparam int TBL_DEPTH  = NUM_STATES * ALPHABET_SIZE;
    localparam int STEP_BITS  = $clog2(MAX_RESCAN + 1);
    localparam int ACT_BITS   = 8;
    localparam int ENT_BITS   = ACT_BITS + 2 + 1 + STATE_BITS;

    // storage modes of a table entry
    localparam logic [1:0] MODE_SKIP   = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_RESCAN = 2'd2;

    localparam logic [ACT_BITS-1:0] ACT_NONE = '0;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_BEGIN = 2'd1,
        FUNC_BYTE  = 2'd2,
        FUNC_END   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_TOKEN   = 2'd0,
        KIND_FINAL   = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_BOUND   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ACT_BITS-1:0]   action;
        logic [1:0]            storage;
        logic                  valid;
        logic [STATE_BITS-1:0] nxt_state;
    } ent_t;

    typedef struct packed {
        func_t                 func;
        logic [CHAR_BITS-1:0]  char_code;
        logic [STATE_BITS-1:0] entry_state;
        logic [STATE_BITS-1:0] entry_next;
        logic                  entry_valid;
        logic [1:0]            entry_storage;
        logic [ACT_BITS-1:0]   entry_action;
        logic [STATE_BITS-1:0] begin_state;
    } in_t;

    typedef struct packed {
        kind_t                 kind;
        logic [POS_BITS-1:0]   token_start;
        logic [POS_BITS-1:0]   token_length;
        logic [ACT_BITS-1:0]   action_code;
        logic [STATE_BITS-1:0] result_state;
        logic                  last;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic clr;
        logic step;
        logic fin;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic emit_req;
        logic step_end;
        logic step_fin;
        logic held;
    } stat_t;

endpackage
`default_nettype wire

@@ src/tdl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ src/tdl_ctrl.sv @@
// Sequencer for the lexer core: table clear, item intake, lookup steps, final result.
// Depends on tdl_pkg.
`default_nettype none
module tdl_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire tdl_pkg::func_t  s_func,
    output logic                 s_ready,
    input  wire tdl_pkg::stat_t  stat,
    output tdl_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.take = s_valid && s_ready_reg;
                if (cmd.take && (s_func inside {tdl_pkg::FUNC_BYTE, tdl_pkg::FUNC_END})) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // send a held token first when another result is due
                if (stat.held && stat.emit_req) begin
                    cmd.flush = 1'b1;
                end else if (!stat.emit_req || stat.out_free) begin
                    // hold while a result is due and the output register is full
                    cmd.step = 1'b1;
                    if (stat.step_end) begin
                        state_next = ST_IDLE;
                    end else if (stat.step_fin) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (stat.held) begin
                    cmd.flush = 1'b1;
                end else if (stat.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

    a_no_reclear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("table clear re-entered outside reset");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> (state_reg == ST_IDLE))
        else $error("ready raised outside idle");

    a_step_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step || cmd.fin) |-> !cmd.take)
        else $error("intake overlaps a lookup step");

endmodule
`default_nettype wire

@@ src/tdl_datapath.sv @@
// Datapath of the lexer core: scanner registers, table port, result register.
// Depends on tdl_pkg and tdl_ram.
`default_nettype none
module tdl_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tdl_pkg::in_t   s_data,
    input  wire tdl_pkg::cmd_t  cmd,
    output tdl_pkg::stat_t      stat,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tdl_pkg::out_t       m_data
);

    localparam int PB = tdl_pkg::POS_BITS;
    localparam int SB = tdl_pkg::STEP_BITS;

    logic [tdl_pkg::STATE_BITS-1:0] cur_reg, cur_next;
    logic [PB-1:0]                  pos_reg, pos_next;
    logic [PB-1:0]                  tb_reg, tb_next;
    logic [PB-1:0]                  cnt_reg, cnt_next;
    logic [tdl_pkg::CHAR_BITS-1:0]  ch_reg, ch_next;
    logic                           end_reg, end_next;
    logic [SB-1:0]                  steps_reg, steps_next;
    tdl_pkg::kind_t                 pend_reg, pend_next;
    tdl_pkg::out_t                  out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           hold_reg, hold_next;
    logic [tdl_pkg::ADDR_BITS-1:0]  clr_addr_reg;

    logic                           ram_we;
    logic [tdl_pkg::ADDR_BITS-1:0]  ram_waddr, ram_raddr;
    logic [tdl_pkg::ENT_BITS-1:0]   ram_wdata, ram_rdata;
    tdl_pkg::ent_t                  ent, wr_ent;

    logic          app, rescan, has_act, tb_eq, bound, fire, step_cont, load_out;
    logic          hold_set, hold_done;
    logic [PB-1:0] cnt_app, pos_adv;

    tdl_ram #(
        .WIDTH (tdl_pkg::ENT_BITS),
        .DEPTH (tdl_pkg::TBL_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent = tdl_pkg::ent_t'(ram_rdata);

    always_comb begin
        wr_ent.action    = s_data.entry_action;
        wr_ent.storage   = s_data.entry_storage;
        wr_ent.valid     = s_data.entry_valid;
        wr_ent.nxt_state = s_data.entry_next;
        ram_we    = cmd.clr || (cmd.take && (s_data.func == tdl_pkg::FUNC_WRITE));
        ram_waddr = cmd.clr ? clr_addr_reg : {s_data.entry_state, s_data.char_code};
        ram_wdata = cmd.clr ? '0 : wr_ent;
    end

    // entry decode
    assign app     = (ent.storage == tdl_pkg::MODE_APPEND);
    assign rescan  = (ent.storage == tdl_pkg::MODE_RESCAN);
    assign has_act = (ent.action != tdl_pkg::ACT_NONE);
    assign tb_eq   = (tb_reg == pos_reg);
    assign bound   = (steps_reg == SB'(tdl_pkg::MAX_RESCAN));
    assign fire    = has_act && (!end_reg || !tb_eq);
    assign cnt_app = cnt_reg + {{(PB-1){1'b0}}, app};
    assign pos_adv = pos_reg + {{(PB-1){1'b0}}, !rescan};

    always_comb begin
        stat.clr_last = &clr_addr_reg;
        stat.out_free = !hold_reg && (!out_valid_reg || m_ready);
        stat.emit_req = !ent.valid || fire;
        stat.step_end = !ent.valid || (!end_reg && !rescan);
        stat.step_fin = ent.valid && (end_reg ? (fire || tb_eq || bound) : (rescan && bound));
        stat.held     = hold_reg;
    end

    assign step_cont = cmd.step && !stat.step_end && !stat.step_fin;
    assign load_out  = (cmd.step && stat.emit_req) || cmd.fin;

    // a token from a rescan lookup is last only if the chain then ends quietly
    assign hold_set  = cmd.step && ent.valid && !end_reg && fire && rescan && !bound;
    assign hold_done = cmd.step && hold_reg && !stat.emit_req && stat.step_end;

    always_comb begin
        if (cmd.take) begin
            ram_raddr = {cur_reg, ch_next};
        end else if (step_cont) begin
            ram_raddr = {ent.nxt_state, ch_reg};
        end else begin
            ram_raddr = {cur_reg, ch_reg};
        end
    end

    always_comb begin
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        tb_next        = tb_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        end_next       = end_reg;
        steps_next     = steps_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        hold_next      = hold_set || (hold_reg && !cmd.flush && !hold_done);

        if (cmd.take) begin
            ch_next    = (s_data.func == tdl_pkg::FUNC_END) ? '0 : s_data.char_code;
            end_next   = (s_data.func == tdl_pkg::FUNC_END);
            steps_next = '0;
            if (s_data.func == tdl_pkg::FUNC_BEGIN) begin
                cur_next = s_data.begin_state;
                pos_next = '0;
                tb_next  = '0;
                cnt_next = '0;
            end
        end

        if (cmd.step) begin
            if (!ent.valid) begin
                out_next = '{kind: tdl_pkg::KIND_INVALID, token_start: tb_reg,
                             token_length: cnt_reg, action_code: tdl_pkg::ACT_NONE,
                             result_state: cur_reg, last: 1'b1};
                pos_next = pos_reg + {{(PB-1){1'b0}}, !end_reg};
            end else if (!end_reg) begin
                cur_next = ent.nxt_state;
                pos_next = pos_adv;
                cnt_next = cnt_app;
                if (fire) begin
                    out_next = '{kind: tdl_pkg::KIND_TOKEN, token_start: tb_reg,
                                 token_length: cnt_app, action_code: ent.action,
                                 result_state: ent.nxt_state, last: !rescan};
                    tb_next  = pos_adv;
                    cnt_next = '0;
                end
                pend_next = tdl_pkg::KIND_BOUND;
            end else begin
                if (fire) begin
                    out_next = '{kind: tdl_pkg::KIND_TOKEN, token_start: tb_reg,
                                 token_length: cnt_reg, action_code: ent.action,
                                 result_state: ent.nxt_state, last: 1'b0};
                    tb_next  = pos_reg;
                    cnt_next = '0;
                end
                // walk bound hit with the token still pending: keep the state
                if (fire || tb_eq || !bound) begin
                    cur_next = ent.nxt_state;
                end
                pend_next = (fire || tb_eq) ? tdl_pkg::KIND_FINAL : tdl_pkg::KIND_BOUND;
            end
            if (!bound) begin
                steps_next = steps_reg + SB'(1);
            end
        end

        // chain ended with no further result: the held token closes the item
        if (hold_done) begin
            out_next.last = 1'b1;
        end

        if (cmd.fin) begin
            out_next = '{kind: pend_reg, token_start: tb_reg, token_length: cnt_reg,
                         action_code: tdl_pkg::ACT_NONE, result_state: cur_reg,
                         last: 1'b1};
            // a byte dropped at the rescan bound still advances the position
            if (!end_reg) begin
                pos_next = pos_reg + {{(PB-1){1'b0}}, 1'b1};
            end
        end

        if ((load_out && !hold_set) || cmd.flush || hold_done) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            pos_reg       <= '0;
            tb_reg        <= '0;
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
            clr_addr_reg  <= '0;
        end else begin
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            tb_reg        <= tb_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
            if (cmd.clr) begin
                clr_addr_reg <= clr_addr_reg + tdl_pkg::ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> stat.out_free)
        else $error("result register loaded while a beat is pending");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (steps_reg <= SB'(tdl_pkg::MAX_RESCAN)))
        else $error("lookup step count beyond rescan bound");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.kind == tdl_pkg::KIND_FINAL)) |-> out_reg.last)
        else $error("end-of-text final result not marked last");

    a_hold_unsent: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg |-> !out_valid_reg)
        else $error("held token presented as a valid beat");

endmodule
`default_nettype wire

@@ src/table_driven_lexer_dfa_core.sv @@
// Top level of the table-driven lexer DFA core: controller, datapath, table RAM.
// Depends on tdl_pkg, tdl_ctrl, tdl_datapath (which holds tdl_ram).
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   tdl_pkg::in_t  (write, begin, byte, end)
//   m_        out        m_valid / m_ready   tdl_pkg::out_t (one result per beat)
//
// After reset the table is swept to invalid, one entry a cycle, all 4096
// entries with s_ready low. Write and begin items need no table read. A text
// byte takes its intake and a table read, another read per rescan lookup, a
// final-result step when the rescan bound is hit, and a flush each time a token
// held back from a rescan lookup must go out before the next result. End of text
// takes its intake and a table read per byte-0 walk step, then the final result;
// a full result register holds the step.
`default_nettype none
module table_driven_lexer_dfa_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tdl_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tdl_pkg::out_t       m_data
);

    tdl_pkg::cmd_t  cmd;
    tdl_pkg::stat_t stat;

    tdl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tdl_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
